// ----- rtl/gel_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge residual loss package
// Shared widths, codes and control structures of the edge residual loss block.
// ----------------------------------------------------------------------------
package gel_pkg;

  localparam int unsigned LANES  = 3;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned IDX_W  = 12;
  localparam int unsigned POS_W  = 24;
  localparam int unsigned REST_W = 25;
  localparam int unsigned RES_W  = 26;
  localparam int unsigned MAG_W  = 25;
  localparam int unsigned SQ_W   = 50;
  localparam int unsigned LOSS_W = 51;
  localparam int unsigned ACC_W  = 32;
  localparam int unsigned SUM_W  = 34;

  localparam logic signed [ACC_W-1:0] ACC_MAX = 32'sh7fff_ffff;
  localparam logic signed [ACC_W-1:0] ACC_MIN = 32'sh8000_0000;

  typedef enum logic [KIND_W-1:0] {
    KIND_REST = 2'd0,
    KIND_LOSS = 2'd1,
    KIND_GRAD = 2'd2,
    KIND_READ = 2'd3
  } kind_e;

  typedef enum logic {
    SORT_LOSS = 1'b0,
    SORT_GRAD = 1'b1
  } sort_e;

  typedef enum logic [1:0] {
    ACC_CLEAR = 2'd0,
    ACC_SUB   = 2'd1,
    ACC_ADD   = 2'd2
  } acc_op_e;

  typedef struct packed {
    logic    d_en;
    logic    rest_wr;
    logic    rest_rd;
    logic    rest_ok;
    logic    res_en;
    logic    sq_en;
    logic    acc_rd;
    logic    acc_wr;
    acc_op_e acc_op;
  } lane_cmd_t;

  typedef struct packed {
    logic  load;
    sort_e sort;
    logic  grad_ok;
  } merge_cmd_t;

endpackage

// ----- rtl/gel_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge residual loss channels
// Valid/ready channels for edge beats in and result beats out.
// ----------------------------------------------------------------------------
interface gel_in_if;
  logic                                   valid;
  logic                                   ready;
  logic        [gel_pkg::KIND_W-1:0]      kind;
  logic        [gel_pkg::IDX_W-1:0]       edge_index;
  logic        [gel_pkg::IDX_W-1:0]       first_vertex;
  logic        [gel_pkg::IDX_W-1:0]       second_vertex;
  logic signed [gel_pkg::POS_W-1:0]       first_x;
  logic signed [gel_pkg::POS_W-1:0]       first_y;
  logic signed [gel_pkg::POS_W-1:0]       first_z;
  logic signed [gel_pkg::POS_W-1:0]       second_x;
  logic signed [gel_pkg::POS_W-1:0]       second_y;
  logic signed [gel_pkg::POS_W-1:0]       second_z;

  modport source (
    output valid, kind, edge_index, first_vertex, second_vertex,
    output first_x, first_y, first_z, second_x, second_y, second_z,
    input  ready
  );
  modport sink (
    input  valid, kind, edge_index, first_vertex, second_vertex,
    input  first_x, first_y, first_z, second_x, second_y, second_z,
    output ready
  );
endinterface

interface gel_out_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   result_sort;
  logic        [gel_pkg::LOSS_W-1:0]      loss_x;
  logic        [gel_pkg::LOSS_W-1:0]      loss_y;
  logic        [gel_pkg::LOSS_W-1:0]      loss_z;
  logic signed [gel_pkg::ACC_W-1:0]       grad_x;
  logic signed [gel_pkg::ACC_W-1:0]       grad_y;
  logic signed [gel_pkg::ACC_W-1:0]       grad_z;

  modport source (
    output valid, result_sort, loss_x, loss_y, loss_z, grad_x, grad_y, grad_z,
    input  ready
  );
  modport sink (
    input  valid, result_sort, loss_x, loss_y, loss_z, grad_x, grad_y, grad_z,
    output ready
  );
endinterface

// ----- rtl/graph_edge_residual_loss_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge residual loss top level
// Edge vector preservation loss: records rest vectors, reports squared
// residuals, accumulates per-vertex gradients and reads and clears them over three axis lanes.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake          Beat
//  in_i     in   valid/ready        one edge: kind, indices, two positions
//  out_o    out  valid/ready        one result: sort, three losses, three grads
//
//  Record beats end in S_IDLE; loss beats pass S_RES, S_SQ, S_OUT; gradient
//  updates S_RES, S_UPD0, S_RD1, S_UPD1; gradient reads S_RES and S_OUT.
//  After reset the gradient stores are cleared, one vertex per cycle, over
//  all VERTEX_COUNT vertices while in_i is not ready.
//  A result waits in the output register; only the next loss or read beat
//  stalls on it.
// ----------------------------------------------------------------------------
module graph_edge_residual_loss_top #(
  parameter int unsigned EDGE_COUNT   = 4096,
  parameter int unsigned VERTEX_COUNT = 4096
) (
  input  logic clk_i,
  input  logic rst_ni,
  gel_in_if.sink    in_i,
  gel_out_if.source out_o
);

  localparam int unsigned EA = (EDGE_COUNT > 1) ? $clog2(EDGE_COUNT) : 1;
  localparam int unsigned VA = $clog2(VERTEX_COUNT);

  gel_pkg::lane_cmd_t                lane_cmd;
  gel_pkg::merge_cmd_t               merge_cmd;
  logic        [EA-1:0]              rest_addr;
  logic        [VA-1:0]              acc_addr;
  logic                              out_free;
  logic signed [gel_pkg::POS_W-1:0]  first_pos  [gel_pkg::LANES];
  logic signed [gel_pkg::POS_W-1:0]  second_pos [gel_pkg::LANES];
  logic        [gel_pkg::SQ_W-1:0]   lane_sq    [gel_pkg::LANES];
  logic signed [gel_pkg::ACC_W-1:0]  lane_grad  [gel_pkg::LANES];
  logic        [gel_pkg::LOSS_W-1:0] loss       [gel_pkg::LANES];
  logic signed [gel_pkg::ACC_W-1:0]  grad       [gel_pkg::LANES];

  assign first_pos[0]  = in_i.first_x;
  assign first_pos[1]  = in_i.first_y;
  assign first_pos[2]  = in_i.first_z;
  assign second_pos[0] = in_i.second_x;
  assign second_pos[1] = in_i.second_y;
  assign second_pos[2] = in_i.second_z;

  gel_ctrl #(
    .EDGE_COUNT   (EDGE_COUNT),
    .VERTEX_COUNT (VERTEX_COUNT)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_i.valid),
    .in_ready_o      (in_i.ready),
    .kind_i          (in_i.kind),
    .edge_index_i    (in_i.edge_index),
    .first_vertex_i  (in_i.first_vertex),
    .second_vertex_i (in_i.second_vertex),
    .out_free_i      (out_free),
    .lane_cmd_o      (lane_cmd),
    .rest_addr_o     (rest_addr),
    .acc_addr_o      (acc_addr),
    .merge_cmd_o     (merge_cmd)
  );

  for (genvar g = 0; g < gel_pkg::LANES; g++) begin : g_lane
    gel_lane #(
      .EDGE_COUNT   (EDGE_COUNT),
      .VERTEX_COUNT (VERTEX_COUNT)
    ) u_lane (
      .clk_i        (clk_i),
      .cmd_i        (lane_cmd),
      .rest_addr_i  (rest_addr),
      .acc_addr_i   (acc_addr),
      .first_pos_i  (first_pos[g]),
      .second_pos_i (second_pos[g]),
      .sq_o         (lane_sq[g]),
      .grad_o       (lane_grad[g])
    );
  end

  gel_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (merge_cmd),
    .sq_i          (lane_sq),
    .grad_i        (lane_grad),
    .out_free_o    (out_free),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .result_sort_o (out_o.result_sort),
    .loss_o        (loss),
    .grad_o        (grad)
  );

  assign out_o.loss_x = loss[0];
  assign out_o.loss_y = loss[1];
  assign out_o.loss_z = loss[2];
  assign out_o.grad_x = grad[0];
  assign out_o.grad_y = grad[1];
  assign out_o.grad_z = grad[2];

endmodule

// ----- rtl/gel_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge residual loss lane
// One axis: rest vector store, gradient store, residual, square and
// saturating gradient update.
// ----------------------------------------------------------------------------
module gel_lane #(
  parameter int unsigned EDGE_COUNT   = 4096,
  parameter int unsigned VERTEX_COUNT = 4096,
  localparam int unsigned EA = (EDGE_COUNT > 1) ? $clog2(EDGE_COUNT) : 1,
  localparam int unsigned VA = $clog2(VERTEX_COUNT)
) (
  input  logic                                clk_i,
  input  gel_pkg::lane_cmd_t                  cmd_i,
  input  logic        [EA-1:0]                rest_addr_i,
  input  logic        [VA-1:0]                acc_addr_i,
  input  logic signed [gel_pkg::POS_W-1:0]    first_pos_i,
  input  logic signed [gel_pkg::POS_W-1:0]    second_pos_i,
  output logic        [gel_pkg::SQ_W-1:0]     sq_o,
  output logic signed [gel_pkg::ACC_W-1:0]    grad_o
);

  logic signed [gel_pkg::REST_W-1:0] rest_mem [EDGE_COUNT];
  logic signed [gel_pkg::ACC_W-1:0]  acc_mem  [VERTEX_COUNT];

  logic signed [gel_pkg::REST_W-1:0] d_in;
  logic signed [gel_pkg::REST_W-1:0] d_q;
  logic signed [gel_pkg::REST_W-1:0] rest_rd_q;
  logic signed [gel_pkg::REST_W-1:0] rest_sel;
  logic signed [gel_pkg::RES_W-1:0]  r_d;
  logic signed [gel_pkg::RES_W-1:0]  r_q;
  logic        [gel_pkg::MAG_W-1:0]  mag;
  logic        [gel_pkg::SQ_W-1:0]   sq_d;
  logic        [gel_pkg::SQ_W-1:0]   sq_q;
  logic signed [gel_pkg::ACC_W-1:0]  acc_rd_q;
  logic signed [gel_pkg::SUM_W-1:0]  sum;
  logic signed [gel_pkg::ACC_W-1:0]  sat;
  logic signed [gel_pkg::ACC_W-1:0]  acc_wdata;

  assign d_in     = gel_pkg::REST_W'(second_pos_i) - gel_pkg::REST_W'(first_pos_i);
  assign rest_sel = cmd_i.rest_ok ? rest_rd_q : '0;
  assign r_d      = gel_pkg::RES_W'(d_q) - gel_pkg::RES_W'(rest_sel);
  assign mag      = r_q[gel_pkg::RES_W-1] ? gel_pkg::MAG_W'(-r_q) : gel_pkg::MAG_W'(r_q);
  assign sq_d     = gel_pkg::SQ_W'(mag) * gel_pkg::SQ_W'(mag);

  always_comb begin
    if (cmd_i.acc_op == gel_pkg::ACC_SUB) begin
      sum = gel_pkg::SUM_W'(acc_rd_q) - gel_pkg::SUM_W'(r_q);
    end else begin
      sum = gel_pkg::SUM_W'(acc_rd_q) + gel_pkg::SUM_W'(r_q);
    end
    if (sum > gel_pkg::SUM_W'(gel_pkg::ACC_MAX)) begin
      sat = gel_pkg::ACC_MAX;
    end else if (sum < gel_pkg::SUM_W'(gel_pkg::ACC_MIN)) begin
      sat = gel_pkg::ACC_MIN;
    end else begin
      sat = gel_pkg::ACC_W'(sum);
    end
    case (cmd_i.acc_op)
      gel_pkg::ACC_CLEAR: acc_wdata = '0;
      gel_pkg::ACC_SUB:   acc_wdata = sat;
      gel_pkg::ACC_ADD:   acc_wdata = sat;
      default:            acc_wdata = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rest_wr) begin
      rest_mem[rest_addr_i] <= d_in;
    end
    if (cmd_i.rest_rd) begin
      rest_rd_q <= rest_mem[rest_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_wr) begin
      acc_mem[acc_addr_i] <= acc_wdata;
    end
    if (cmd_i.acc_rd) begin
      acc_rd_q <= acc_mem[acc_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.d_en) begin
      d_q <= d_in;
    end
    if (cmd_i.res_en) begin
      r_q <= r_d;
    end
    if (cmd_i.sq_en) begin
      sq_q <= sq_d;
    end
  end

  assign sq_o   = sq_q;
  assign grad_o = acc_rd_q;

endmodule

// ----- rtl/gel_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge residual loss sequencer
// Clears the gradient stores after reset, then steps each edge beat through
// read, residual, square or read-modify-write, and hands results to the merge.
// ----------------------------------------------------------------------------
module gel_ctrl #(
  parameter int unsigned EDGE_COUNT   = 4096,
  parameter int unsigned VERTEX_COUNT = 4096,
  localparam int unsigned EA = (EDGE_COUNT > 1) ? $clog2(EDGE_COUNT) : 1,
  localparam int unsigned VA = $clog2(VERTEX_COUNT)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [gel_pkg::KIND_W-1:0]    kind_i,
  input  logic [gel_pkg::IDX_W-1:0]     edge_index_i,
  input  logic [gel_pkg::IDX_W-1:0]     first_vertex_i,
  input  logic [gel_pkg::IDX_W-1:0]     second_vertex_i,
  input  logic                          out_free_i,
  output gel_pkg::lane_cmd_t            lane_cmd_o,
  output logic [EA-1:0]                 rest_addr_o,
  output logic [VA-1:0]                 acc_addr_o,
  output gel_pkg::merge_cmd_t           merge_cmd_o
);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_RES   = 8'b0000_0100,
    S_SQ    = 8'b0000_1000,
    S_UPD0  = 8'b0001_0000,
    S_RD1   = 8'b0010_0000,
    S_UPD1  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  localparam logic [VA-1:0] CLR_LAST = VA'(VERTEX_COUNT - 1);

  state_e            state_q, state_d;
  logic [VA-1:0]     clr_q, clr_d;
  gel_pkg::kind_e    kind_q, kind_d;
  logic              e_ok_q, e_ok_d;
  logic              v0_ok_q, v0_ok_d;
  logic              v1_ok_q, v1_ok_d;
  logic [VA-1:0]     v0_q, v0_d;
  logic [VA-1:0]     v1_q, v1_d;

  gel_pkg::kind_e    kind_in;
  logic              e_ok_in;
  logic              v0_ok_in;
  logic              v1_ok_in;
  logic              accept;

  assign kind_in  = gel_pkg::kind_e'(kind_i);
  assign e_ok_in  = 32'(edge_index_i) < EDGE_COUNT;
  assign v0_ok_in = 32'(first_vertex_i) < VERTEX_COUNT;
  assign v1_ok_in = 32'(second_vertex_i) < VERTEX_COUNT;
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign rest_addr_o = EA'(edge_index_i);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    kind_d  = kind_q;
    e_ok_d  = e_ok_q;
    v0_ok_d = v0_ok_q;
    v1_ok_d = v1_ok_q;
    v0_d    = v0_q;
    v1_d    = v1_q;
    lane_cmd_o  = '0;
    merge_cmd_o = '0;
    acc_addr_o  = v0_q;
    merge_cmd_o.sort    = (kind_q == gel_pkg::KIND_READ) ? gel_pkg::SORT_GRAD
                                                         : gel_pkg::SORT_LOSS;
    merge_cmd_o.grad_ok = v0_ok_q;
    lane_cmd_o.rest_ok  = e_ok_q;
    case (state_q)
      S_CLEAR: begin
        acc_addr_o        = clr_q;
        lane_cmd_o.acc_wr = 1'b1;
        lane_cmd_o.acc_op = gel_pkg::ACC_CLEAR;
        clr_d             = clr_q + VA'(1);
        if (clr_q == CLR_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        acc_addr_o = VA'(first_vertex_i);
        if (accept) begin
          kind_d  = kind_in;
          e_ok_d  = e_ok_in;
          v0_ok_d = v0_ok_in;
          v1_ok_d = v1_ok_in;
          v0_d    = VA'(first_vertex_i);
          v1_d    = VA'(second_vertex_i);
          lane_cmd_o.d_en    = 1'b1;
          lane_cmd_o.rest_wr = e_ok_in && (kind_in == gel_pkg::KIND_REST);
          lane_cmd_o.rest_rd = e_ok_in && ((kind_in == gel_pkg::KIND_LOSS) ||
                                           (kind_in == gel_pkg::KIND_GRAD));
          lane_cmd_o.acc_rd  = v0_ok_in && ((kind_in == gel_pkg::KIND_GRAD) ||
                                            (kind_in == gel_pkg::KIND_READ));
          if (kind_in != gel_pkg::KIND_REST) begin
            state_d = S_RES;
          end
        end
      end
      S_RES: begin
        lane_cmd_o.res_en = 1'b1;
        lane_cmd_o.acc_wr = v0_ok_q && (kind_q == gel_pkg::KIND_READ);
        lane_cmd_o.acc_op = gel_pkg::ACC_CLEAR;
        case (kind_q)
          gel_pkg::KIND_LOSS: state_d = S_SQ;
          gel_pkg::KIND_GRAD: state_d = S_UPD0;
          gel_pkg::KIND_READ: state_d = S_OUT;
          default:            state_d = S_IDLE;
        endcase
      end
      S_SQ: begin
        lane_cmd_o.sq_en = 1'b1;
        state_d          = S_OUT;
      end
      S_UPD0: begin
        lane_cmd_o.acc_wr = v0_ok_q;
        lane_cmd_o.acc_op = gel_pkg::ACC_SUB;
        state_d           = S_RD1;
      end
      S_RD1: begin
        acc_addr_o        = v1_q;
        lane_cmd_o.acc_rd = v1_ok_q;
        state_d           = S_UPD1;
      end
      S_UPD1: begin
        acc_addr_o        = v1_q;
        lane_cmd_o.acc_wr = v1_ok_q;
        lane_cmd_o.acc_op = gel_pkg::ACC_ADD;
        state_d           = S_IDLE;
      end
      S_OUT: begin
        merge_cmd_o.load = out_free_i;
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    e_ok_q  <= e_ok_d;
    v0_ok_q <= v0_ok_d;
    v1_ok_q <= v1_ok_d;
    v0_q    <= v0_d;
    v1_q    <= v1_d;
  end

`ifndef SYNTHESIS
  // A result is only handed over when the output register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    merge_cmd_o.load |-> out_free_i)
    else $error("result loaded into an occupied output register");

  // The gradient store is never read and written in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(lane_cmd_o.acc_rd && lane_cmd_o.acc_wr))
    else $error("gradient store read and written together");

  // A rest vector is only written by an accepted beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_cmd_o.rest_wr |-> accept)
    else $error("rest vector written without an accepted beat");

  // A record beat leaves the sequencer ready in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (kind_in == gel_pkg::KIND_REST)) |=> in_ready_o)
    else $error("record beat did not complete in one cycle");

  // A gradient update always follows the first write with the second read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD0) |=> (state_q == S_RD1))
    else $error("gradient update sequence broken");
`endif

endmodule

// ----- rtl/gel_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge residual loss merge
// Gathers the three lane results into one result beat and holds it in the
// output register until it is taken.
// ----------------------------------------------------------------------------
module gel_merge (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gel_pkg::merge_cmd_t               cmd_i,
  input  logic        [gel_pkg::SQ_W-1:0]   sq_i   [gel_pkg::LANES],
  input  logic signed [gel_pkg::ACC_W-1:0]  grad_i [gel_pkg::LANES],
  output logic                              out_free_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              result_sort_o,
  output logic        [gel_pkg::LOSS_W-1:0] loss_o [gel_pkg::LANES],
  output logic signed [gel_pkg::ACC_W-1:0]  grad_o [gel_pkg::LANES]
);

  logic                              valid_q, valid_d;
  logic                              sort_q;
  logic        [gel_pkg::LOSS_W-1:0] loss_q [gel_pkg::LANES];
  logic signed [gel_pkg::ACC_W-1:0]  grad_q [gel_pkg::LANES];

  assign out_free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sort_q <= cmd_i.sort;
      for (int i = 0; i < gel_pkg::LANES; i++) begin
        loss_q[i] <= (cmd_i.sort == gel_pkg::SORT_LOSS) ?
                     gel_pkg::LOSS_W'(sq_i[i]) : '0;
        grad_q[i] <= ((cmd_i.sort == gel_pkg::SORT_GRAD) && cmd_i.grad_ok) ?
                     grad_i[i] : '0;
      end
    end
  end

  assign out_valid_o   = valid_q;
  assign result_sort_o = sort_q;
  assign loss_o        = loss_q;
  assign grad_o        = grad_q;

endmodule
